// ----- sv/dll_pkg.sv -----
// ----------------------------------------------------------------------------
// dll_pkg
// Opcodes and status codes used by the linked list engine core.
// ----------------------------------------------------------------------------
package dll_pkg;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_DELETE    = 3'd2,
    OP_FORWARD   = 3'd3,
    OP_BACKWARD  = 3'd4,
    OP_CLEAR     = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

endpackage

// ----- sv/doubly_linked_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_core
// Doubly linked list of signed values kept in a fixed node pool.
// ----------------------------------------------------------------------------
// The engine keeps a doubly linked list in a pool of NODE_COUNT nodes. Each
// request carries an opcode and a value; inserts, deletes and clear give one
// status response, traversals give one response per node with tlast on the
// final one (or one "empty" response). One request is handled at a time, and
// a new request is taken only after the previous response has been taken.
// All node state lives in three RAMs (values, next links, previous links)
// with registered reads, so each node visited takes a read state and a use
// state. An insert takes the free head, writes the new node and its links,
// then links its neighbour and responds. A delete that finds a match
// relinks the neighbours and returns the node to the free chain; one that
// finds none responds not found. A traversal presents one response per node
// visited while the receiver keeps up. A full pool, an empty traversal and
// a clear respond on the cycle after acceptance. After reset and after a
// clear request the next-link RAM is rebuilt as a free chain by a sweep over
// all NODE_COUNT entries during which no request is accepted.
// Node links use NODE_COUNT as the null marker.
module doubly_linked_list_engine_core #(
  parameter int NODE_COUNT  = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: opcode[2:0], value[34:3], zero fill [39:35].
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: out_value[31:0], status[33:32], zero fill [39:34].
  output logic [39:0] m_tdata,
  output logic        m_tlast
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int LW = $clog2(NODE_COUNT + 1);
  localparam logic [LW-1:0] NIL = LW'(NODE_COUNT);
  localparam int SW = $clog2(NODE_COUNT + 1);

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_INS_RD, S_INS_WR, S_WALK_RD, S_WALK_USE,
    S_DEL_LINK, S_OUT
  } state_t;

  state_t state;
  logic [2:0] op;
  logic [VALUE_WIDTH-1:0] key;
  logic [LW-1:0] head, tail, free_head, cur, node, prev_n, next_n;
  logic [SW-1:0] steps;
  logic [AW-1:0] sweep_idx;
  logic del_stage;

  // Output holding register.
  logic        out_valid;
  logic [31:0] out_val;
  logic [1:0]  out_st;
  logic        out_last;

  // RAM ports.
  logic                   v_we, n_we, p_we;
  logic [AW-1:0]          v_wa, n_wa, p_wa, v_ra, n_ra, p_ra;
  logic [VALUE_WIDTH-1:0] v_wd, v_rd;
  logic [LW-1:0]          n_wd, n_rd, p_wd, p_rd;

  dll_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(NODE_COUNT)) u_val (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
  dll_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_next (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
  dll_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

  logic [2:0]  in_op;
  logic [31:0] in_val;
  logic        accept;
  assign in_op  = s_tdata[2:0];
  assign in_val = s_tdata[34:3];
  assign s_tready = (state == S_IDLE) && !out_valid;
  assign accept = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_st, out_val};
  assign m_tlast  = out_last;

  // Sign-extended read value in 32-bit output form.
  logic [31:0] out_form;
  always_comb begin
    logic [63:0] w;
    w = 64'($signed(v_rd));
    out_form = w[31:0];
  end

  logic [VALUE_WIDTH-1:0] in_store;
  always_comb begin
    logic [63:0] w;
    w = 64'($signed(in_val));
    in_store = w[VALUE_WIDTH-1:0];
  end

  logic fwd;
  assign fwd = (op != 3'(dll_pkg::OP_BACKWARD));

  // Read addresses: the walk reads the current node in all three RAMs; in idle the next-link RAM reads the free head.
  always_comb begin
    v_ra = cur[AW-1:0];
    n_ra = (state == S_IDLE) ? free_head[AW-1:0] : cur[AW-1:0];
    p_ra = cur[AW-1:0];
  end

  // Write ports.
  always_comb begin
    v_we = 1'b0; v_wa = node[AW-1:0]; v_wd = key;
    n_we = 1'b0; n_wa = node[AW-1:0]; n_wd = '0;
    p_we = 1'b0; p_wa = node[AW-1:0]; p_wd = '0;
    case (state)
      S_SWEEP: begin
        n_we = 1'b1; n_wa = sweep_idx; n_wd = LW'(sweep_idx) + LW'(1);
        p_we = 1'b1; p_wa = sweep_idx; p_wd = '0;
      end
      S_INS_WR: begin
        v_we = 1'b1;
        if (op == 3'(dll_pkg::OP_INS_FRONT)) begin
          n_we = 1'b1; n_wd = head;
          p_we = 1'b1; p_wd = NIL;
        end else begin
          n_we = 1'b1; n_wd = NIL;
          p_we = 1'b1; p_wd = tail;
        end
      end
      S_DEL_LINK: begin
        if (!del_stage) begin
          n_we = (prev_n != NIL); n_wa = prev_n[AW-1:0]; n_wd = next_n;
          p_we = (next_n != NIL); p_wa = next_n[AW-1:0]; p_wd = prev_n;
        end else begin
          n_we = 1'b1; n_wa = cur[AW-1:0]; n_wd = free_head;
        end
      end
      S_OUT: begin
        // Second link of an insert: old head's prev or old tail's next.
        // The flag is only set when the list held a node before the insert.
        if (del_stage) begin
          if (op == 3'(dll_pkg::OP_INS_FRONT)) begin
            p_we = 1'b1; p_wa = cur[AW-1:0]; p_wd = node;
          end else begin
            n_we = 1'b1; n_wa = cur[AW-1:0]; n_wd = node;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      sweep_idx <= '0;
      head <= NIL; tail <= NIL; free_head <= '0;
      out_valid <= 1'b0;
      del_stage <= 1'b0;
    end else begin
      if (out_valid && m_tready) out_valid <= 1'b0;
      case (state)
        S_SWEEP: begin
          sweep_idx <= sweep_idx + AW'(1);
          if (sweep_idx == AW'(NODE_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            op <= in_op; key <= in_store; steps <= '0; del_stage <= 1'b0;
            case (in_op)
              3'(dll_pkg::OP_INS_FRONT), 3'(dll_pkg::OP_INS_BACK): begin
                if (free_head == NIL) begin
                  out_valid <= 1'b1; out_val <= '0; out_last <= 1'b1;
                  out_st <= dll_pkg::ST_FULL;
                end else begin
                  node <= free_head; state <= S_INS_RD;
                end
              end
              3'(dll_pkg::OP_DELETE): begin
                cur <= head; state <= S_WALK_RD;
              end
              3'(dll_pkg::OP_FORWARD), 3'(dll_pkg::OP_BACKWARD): begin
                if (head == NIL) begin
                  out_valid <= 1'b1; out_val <= '0; out_last <= 1'b1;
                  out_st <= dll_pkg::ST_EMPTY;
                end else begin
                  cur <= (in_op == 3'(dll_pkg::OP_FORWARD)) ? head : tail;
                  state <= S_WALK_RD;
                end
              end
              3'(dll_pkg::OP_CLEAR): begin
                head <= NIL; tail <= NIL; free_head <= '0; sweep_idx <= '0;
                out_valid <= 1'b1; out_val <= '0; out_last <= 1'b1;
                out_st <= dll_pkg::ST_OK;
                state <= S_SWEEP;
              end
              default: ;
            endcase
          end
        end
        S_INS_RD: begin
          // n_rd now holds next link of the free head.
          free_head <= n_rd;
          state <= S_INS_WR;
        end
        S_INS_WR: begin
          if (op == 3'(dll_pkg::OP_INS_FRONT)) begin
            if (head == NIL) tail <= node;
            cur <= head; head <= node;
            del_stage <= (head != NIL);
          end else begin
            if (tail == NIL) head <= node;
            cur <= tail; tail <= node;
            del_stage <= (tail != NIL);
          end
          state <= S_OUT;
        end
        S_WALK_RD: begin
          if (cur == NIL || steps == SW'(NODE_COUNT)) begin
            // Only a delete can get here without a node.
            out_valid <= 1'b1; out_val <= '0; out_last <= 1'b1;
            out_st <= dll_pkg::ST_NOT_FOUND;
            state <= S_IDLE;
          end else begin
            state <= S_WALK_USE;
          end
        end
        S_WALK_USE: begin
          if (op == 3'(dll_pkg::OP_DELETE)) begin
            if (v_rd == key) begin
              prev_n <= p_rd; next_n <= n_rd;
              state <= S_DEL_LINK;
            end else begin
              cur <= n_rd; steps <= steps + SW'(1); state <= S_WALK_RD;
            end
          end else if (!out_valid || m_tready) begin
            logic [LW-1:0] nx;
            nx = fwd ? n_rd : p_rd;
            out_valid <= 1'b1; out_val <= out_form; out_st <= dll_pkg::ST_OK;
            out_last <= (nx == NIL) || (steps == SW'(NODE_COUNT - 1));
            if ((nx == NIL) || (steps == SW'(NODE_COUNT - 1))) begin
              state <= S_IDLE;
            end else begin
              cur <= nx; steps <= steps + SW'(1); state <= S_WALK_RD;
            end
          end
        end
        S_DEL_LINK: begin
          if (!del_stage) begin
            if (prev_n == NIL) head <= next_n;
            if (next_n == NIL) tail <= prev_n;
            del_stage <= 1'b1;
          end else begin
            free_head <= cur;
            del_stage <= 1'b0;
            out_valid <= 1'b1; out_val <= '0; out_last <= 1'b1;
            out_st <= dll_pkg::ST_OK;
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          del_stage <= 1'b0;
          out_valid <= 1'b1; out_val <= '0; out_last <= 1'b1;
          out_st <= dll_pkg::ST_OK;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A held response must not change until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |=> out_valid && $stable(out_val) && $stable(out_last))
    else $error("response changed while stalled");
  // No request is taken during the pool rebuild.
  a_sweep: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP |-> !s_tready)
    else $error("request accepted during sweep");
  // Head and tail are null together.
  a_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> ((head == NIL) == (tail == NIL)))
    else $error("head and tail disagree");

endmodule

// ----- sv/dll_ram.sv -----
// ----------------------------------------------------------------------------
// dll_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
